// ===== sv/asa_pkg.sv =====
package asa_pkg;

    localparam int ADDR_W           = 32;
    localparam int ADJ_W            = 8;
    localparam int ENTRY_W          = ADDR_W + ADJ_W;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int STACK_DEPTH_DEF  = 64;
    localparam int CNT_W_DEF        = $clog2(STACK_DEPTH_DEF + 1);
    localparam int CFG_IDX_W        = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_NOROOM = 3'd2,
        ST_BADREL = 3'd3,
        ST_FULL   = 3'd4,
        ST_EMPTY  = 3'd5
    } t_status;

endpackage

// ===== sv/asa_req_if.sv =====
interface asa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [asa_pkg::ADDR_W-1:0]  request_bytes;
    logic [2:0]                  align_shift;
    logic [asa_pkg::ADDR_W-1:0]  release_address;

    modport source (
        output valid, op, request_bytes, align_shift, release_address,
        input  ready
    );
    modport sink (
        input  valid, op, request_bytes, align_shift, release_address,
        output ready
    );
endinterface

// ===== sv/asa_rsp_if.sv =====
interface asa_rsp_if #(
    parameter int CNT_W = asa_pkg::CNT_W_DEF
);
    logic                        valid;
    logic                        ready;
    asa_pkg::t_status            status;
    logic [asa_pkg::ADDR_W-1:0]  granted_address;
    logic [asa_pkg::ADDR_W-1:0]  used_bytes;
    logic [CNT_W-1:0]            live_count;

    modport source (
        output valid, status, granted_address, used_bytes, live_count,
        input  ready
    );
    modport sink (
        input  valid, status, granted_address, used_bytes, live_count,
        output ready
    );
endinterface

// ===== sv/aligned_stack_allocator_unit.sv =====
// channel   dir  handshake          word
// i_req     in   valid/ready        op, request_bytes, align_shift, release_address
// o_rsp     out  valid/ready        status, granted_address, used_bytes, live_count
// i_cfg_*   in   i_cfg_wr_en only   i_cfg_index, i_cfg_data (base, pool size)
//
// One 34-bit adder/subtractor is stepped by a sequencer; ready is high only when idle.
// Allocate: position, header adjustment, total and room check, push, top update in two steps,
// then output; release checks the top entry, then steps current, subtract, adjust, used, base, top.
// The output register decouples the sides: a new word is taken while a result waits,
// and the sequencer holds in its last step only if the previous result is unclaimed.
// Synchronous reset clears state, config, offsets, count and output valid; data registers and stack memory are not.
module aligned_stack_allocator_unit #(
    parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES_DEF,
    parameter int STACK_DEPTH  = asa_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [asa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [asa_pkg::ADDR_W-1:0]     i_cfg_data,
    asa_req_if.sink                        i_req,
    asa_rsp_if.source                      o_rsp
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W = asa_pkg::ADDR_W + 2;
    localparam int DW    = asa_pkg::ADDR_W;
    localparam int JW    = asa_pkg::ADJ_W;
    localparam logic [8:0] HDR9 = 9'(HEADER_BYTES);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_A_POS  = 15'b000000000000010,
        S_A_ADJ  = 15'b000000000000100,
        S_A_TOT  = 15'b000000000001000,
        S_A_PUSH = 15'b000000000010000,
        S_A_TOP1 = 15'b000000000100000,
        S_A_TOP2 = 15'b000000001000000,
        S_R_CHK  = 15'b000000010000000,
        S_R_CUR  = 15'b000000100000000,
        S_R_SUB  = 15'b000001000000000,
        S_R_ADJ  = 15'b000010000000000,
        S_R_USED = 15'b000100000000000,
        S_R_BASE = 15'b001000000000000,
        S_R_TOP  = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    // smallest adjustment >= header that aligns the position
    function automatic logic [JW-1:0] f_hdr_adj(input logic [6:0] pos_lo,
                                                input logic [2:0] shift);
        logic [7:0] align;
        logic [7:0] mask;
        logic [8:0] adj0;
        logic [8:0] need;
        logic [8:0] step;
        logic [8:0] adj;
        align = 8'd1 << shift;
        mask  = align - 8'd1;
        adj0  = {1'b0, (align - {1'b0, pos_lo}) & mask};
        adj   = adj0;
        if (adj0 < HDR9) begin
            need = HDR9 - adj0;
            step = (need + {1'b0, mask}) & ~{1'b0, mask};
            adj  = adj0 + step;
        end
        return adj[JW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [DW-1:0]     r_base, n_base;
    logic [DW-1:0]     r_pool, n_pool;
    logic [DW-1:0]     r_top, n_top;
    logic [DW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [DW-1:0]     r_pos, n_pos;
    logic [JW-1:0]     r_adj, n_adj;
    logic [DW-1:0]     r_grant, n_grant;
    asa_pkg::t_status  r_status, n_status;
    logic [DW-1:0]     r_req, n_req;
    logic [2:0]        r_shift, n_shift;
    logic [DW-1:0]     r_rel, n_rel;
    logic              r_ovalid, n_ovalid;
    asa_pkg::t_status  r_o_status, n_o_status;
    logic [DW-1:0]     r_o_grant, n_o_grant;
    logic [DW-1:0]     r_o_used, n_o_used;
    logic [CW-1:0]     r_o_cnt, n_o_cnt;
    logic [asa_pkg::ENTRY_W-1:0] r_rd;

    logic [asa_pkg::ENTRY_W-1:0] mem [STACK_DEPTH];

    logic              w_in_acc;
    logic [CW-1:0]     w_cnt_m1;
    logic [SUM_W-1:0]  w_a, w_b, w_sum;
    logic              w_sub;
    logic [JW-1:0]     w_hdr_adj;
    logic [DW-1:0]     w_rd_addr;
    logic [JW-1:0]     w_rd_adj;
    logic              w_push;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && (r_state == S_IDLE);
    assign w_cnt_m1    = r_cnt - CW'(1);
    assign w_hdr_adj   = f_hdr_adj(r_pos[6:0], r_shift);
    assign w_rd_addr   = r_rd[asa_pkg::ENTRY_W-1:JW];
    assign w_rd_adj    = r_rd[JW-1:0];
    assign w_push      = (r_state == S_A_PUSH);

    // shared adder operand selection
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        case (r_state)
            S_A_POS:  begin w_a = SUM_W'(r_base);  w_b = SUM_W'(r_top);      end
            S_A_ADJ:  begin w_a = SUM_W'(r_used);  w_b = SUM_W'(w_hdr_adj);  end
            S_A_TOT:  begin w_a = r_acc;           w_b = SUM_W'(r_req);      end
            S_A_PUSH: begin w_a = SUM_W'(r_pos);   w_b = SUM_W'(r_adj);      end
            S_A_TOP1: begin w_a = SUM_W'(r_top);   w_b = SUM_W'(r_adj);      end
            S_A_TOP2: begin w_a = r_acc;           w_b = SUM_W'(r_req);      end
            S_R_CUR:  begin w_a = SUM_W'(r_base);  w_b = SUM_W'(r_top);      end
            S_R_SUB:  begin
                w_a = r_acc; w_b = SUM_W'(w_rd_addr); w_sub = 1'b1;
            end
            S_R_ADJ:  begin w_a = r_acc;           w_b = SUM_W'(w_rd_adj);   end
            S_R_USED: begin
                w_a = SUM_W'(r_used); w_b = r_acc; w_sub = 1'b1;
            end
            S_R_BASE: begin
                w_a = SUM_W'(w_rd_addr); w_b = SUM_W'(w_rd_adj); w_sub = 1'b1;
            end
            S_R_TOP:  begin
                w_a = r_acc; w_b = SUM_W'(r_base); w_sub = 1'b1;
            end
            default:  begin w_a = '0; w_b = '0; w_sub = 1'b0; end
        endcase
    end

    assign w_sum = w_a + (w_sub ? ~w_b : w_b) + SUM_W'(w_sub);

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_pool     = r_pool;
        n_top      = r_top;
        n_used     = r_used;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_pos      = r_pos;
        n_adj      = r_adj;
        n_grant    = r_grant;
        n_status   = r_status;
        n_req      = r_req;
        n_shift    = r_shift;
        n_rel      = r_rel;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_grant  = r_o_grant;
        n_o_used   = r_o_used;
        n_o_cnt    = r_o_cnt;

        if (i_cfg_wr_en) begin
            if (i_cfg_index == asa_pkg::CFG_BASE) n_base = i_cfg_data;
            if (i_cfg_index == asa_pkg::CFG_POOL) n_pool = i_cfg_data;
        end

        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_req    = i_req.request_bytes;
                    n_shift  = i_req.align_shift;
                    n_rel    = i_req.release_address;
                    n_grant  = '0;
                    n_status = asa_pkg::ST_OK;
                    if (i_req.op == asa_pkg::OP_ALLOC) begin
                        if (i_req.request_bytes == '0) begin
                            n_status = asa_pkg::ST_ZERO;
                            n_state  = S_OUT;
                        end else if (r_cnt == CW'(STACK_DEPTH)) begin
                            n_status = asa_pkg::ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_A_POS;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = asa_pkg::ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_R_CHK;
                        end
                    end
                end
            end
            S_A_POS: begin
                n_pos   = w_sum[DW-1:0];
                n_state = S_A_ADJ;
            end
            S_A_ADJ: begin
                n_adj   = w_hdr_adj;
                n_acc   = w_sum;
                n_state = S_A_TOT;
            end
            S_A_TOT: begin
                n_acc = w_sum;
                if (w_sum > SUM_W'(r_pool)) begin
                    n_status = asa_pkg::ST_NOROOM;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_A_PUSH;
                end
            end
            S_A_PUSH: begin
                n_grant = w_sum[DW-1:0];
                n_used  = r_acc[DW-1:0];
                n_state = S_A_TOP1;
            end
            S_A_TOP1: begin
                n_acc   = w_sum;
                n_state = S_A_TOP2;
            end
            S_A_TOP2: begin
                n_top   = w_sum[DW-1:0];
                n_cnt   = r_cnt + CW'(1);
                n_state = S_OUT;
            end
            S_R_CHK: begin
                if (r_rel == '0 || r_rel != w_rd_addr) begin
                    n_status = asa_pkg::ST_BADREL;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_R_CUR;
                end
            end
            S_R_CUR: begin
                n_acc   = w_sum;
                n_state = S_R_SUB;
            end
            S_R_SUB: begin
                n_acc   = SUM_W'(w_sum[DW-1:0]);
                n_state = S_R_ADJ;
            end
            S_R_ADJ: begin
                n_acc   = SUM_W'(w_sum[DW-1:0]);
                n_state = S_R_USED;
            end
            S_R_USED: begin
                n_used  = w_sum[DW-1:0];
                n_state = S_R_BASE;
            end
            S_R_BASE: begin
                n_acc   = SUM_W'(w_sum[DW-1:0]);
                n_state = S_R_TOP;
            end
            S_R_TOP: begin
                n_top   = w_sum[DW-1:0];
                n_cnt   = w_cnt_m1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_grant  = r_grant;
                    n_o_used   = r_used;
                    n_o_cnt    = r_cnt;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_pool   <= '0;
            r_top    <= '0;
            r_used   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_pool   <= n_pool;
            r_top    <= n_top;
            r_used   <= n_used;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_pos      <= n_pos;
        r_adj      <= n_adj;
        r_grant    <= n_grant;
        r_status   <= n_status;
        r_req      <= n_req;
        r_shift    <= n_shift;
        r_rel      <= n_rel;
        r_o_status <= n_o_status;
        r_o_grant  <= n_o_grant;
        r_o_used   <= n_o_used;
        r_o_cnt    <= n_o_cnt;
    end

    // entry stack: push at the current count, top read issued on accepting a release
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem[r_cnt[AW-1:0]] <= {w_sum[DW-1:0], r_adj};
        end
        if (w_in_acc && i_req.op == asa_pkg::OP_RELEASE) begin
            r_rd <= mem[w_cnt_m1[AW-1:0]];
        end
    end

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.granted_address = r_o_grant;
    assign o_rsp.used_bytes      = r_o_used;
    assign o_rsp.live_count      = r_o_cnt;

endmodule
